### rtl/lsp_pkg.sv
// shared types, constants and codes for the line sensor position pid block
`default_nettype none
package lsp_pkg;

  localparam int NUM_SENSORS  = 8;
  localparam int SAMPLE_BITS  = 10;
  localparam int IDX_W        = $clog2(NUM_SENSORS);
  localparam int FULL_SCALE   = 1000;
  localparam int VAL_W        = 11;
  localparam int NUM_W        = 20;
  localparam int DIV_W        = 25;
  localparam int QUO_W        = 12;
  localparam int CNT_W        = 4;
  localparam int NORM_STEPS   = 10;
  localparam int CENT_STEPS   = 12;
  localparam int WS_W         = 26;
  localparam int SUM_W        = 14;
  localparam int MUL_W        = 17;
  localparam int PROD_W       = 34;
  localparam int ACC_W        = 36;
  localparam int POS_W        = 13;
  localparam int OUT_W        = 16;
  localparam int DRV_W        = 9;
  localparam int OUT_LIMIT    = 32767;

  // operation codes
  localparam logic [2:0] FUNC_CAL   = 3'd0;
  localparam logic [2:0] FUNC_FIN   = 3'd1;
  localparam logic [2:0] FUNC_TRACK = 3'd2;
  localparam logic [2:0] FUNC_POS   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  // register indexes
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_BASE      = 3'd3;
  localparam logic [2:0] REG_DRV_LIM   = 3'd4;
  localparam logic [2:0] REG_INT_LIM   = 3'd5;
  localparam logic [2:0] REG_MIN_SPAN  = 3'd6;

  // sensor weights, left to right
  localparam logic signed [POS_W-1:0] WEIGHTS [NUM_SENSORS] =
    '{-13'sd3500, -13'sd2500, -13'sd1500, -13'sd500,
      13'sd500, 13'sd1500, 13'sd2500, 13'sd3500};

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [NUM_SENSORS-1:0] sample_arr_t;

  typedef struct packed {
    sample_t smin;
    sample_t span;
    logic    valid;
  } cal_rd_t;

endpackage
`default_nettype wire

### rtl/lsp_if.sv
// request, result and register write channel interfaces
`default_nettype none
interface lsp_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [9:0] sample_0;
  logic [9:0] sample_1;
  logic [9:0] sample_2;
  logic [9:0] sample_3;
  logic [9:0] sample_4;
  logic [9:0] sample_5;
  logic [9:0] sample_6;
  logic [9:0] sample_7;
  modport source (output valid, func, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, input ready);
  modport sink (input valid, func, sample_0, sample_1, sample_2, sample_3,
                sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface lsp_res_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] position;
  logic signed [15:0] line_output;
  logic signed [8:0]  left_drive;
  logic signed [8:0]  right_drive;
  logic [7:0]         valid_mask;
  logic               calibrated;
  modport source (output valid, position, line_output, left_drive, right_drive,
                  valid_mask, calibrated, input ready);
  modport sink (input valid, position, line_output, left_drive, right_drive,
                valid_mask, calibrated, output ready);
endinterface

interface lsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/lsp_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module lsp_div
  import lsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,   // already aligned to the top quotient bit
  input  logic [CNT_W-1:0] steps_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o
);

  logic [DIV_W-1:0] rem_q, dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic             ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - dsh_q;
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q)) else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("divider done held");

endmodule
`default_nettype wire

### rtl/lsp_cal.sv
// per-sensor calibration store: running min/max, span and valid bits
`default_nettype none
module lsp_cal
  import lsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  logic [2:0]       func_i,
  input  sample_arr_t      raw_i,
  input  logic [9:0]       min_span_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output cal_rd_t          rd_o,
  output logic [7:0]       valid_mask_o,
  output logic             calibrated_o
);

  sample_t                 min_q [NUM_SENSORS];
  sample_t                 max_q [NUM_SENSORS];
  sample_t                 span_q [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]  valid_q;
  logic                    cal_q;
  sample_t                 fin_span [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]  fin_ok;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      fin_span[i] = '0;
      fin_ok[i]   = 1'b0;
      if (max_q[i] >= min_q[i]) begin
        fin_span[i] = max_q[i] - min_q[i];
        fin_ok[i]   = (fin_span[i] != '0) && (fin_span[i] >= min_span_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        min_q[i]  <= '1;
        max_q[i]  <= '0;
        span_q[i] <= '0;
      end
      valid_q <= '0;
      cal_q   <= 1'b0;
    end else if (upd_i) begin
      if (func_i == FUNC_CAL) begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          if (raw_i[i] < min_q[i]) min_q[i] <= raw_i[i];
          if (raw_i[i] > max_q[i]) max_q[i] <= raw_i[i];
        end
      end else if (func_i == FUNC_FIN) begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          span_q[i] <= fin_ok[i] ? fin_span[i] : '0;
        end
        valid_q <= fin_ok;
        cal_q   <= 1'b1;
      end
    end
  end

  assign rd_o         = '{smin: min_q[rd_idx_i], span: span_q[rd_idx_i],
                          valid: valid_q[rd_idx_i]};
  assign valid_mask_o = valid_q[7:0];
  assign calibrated_o = cal_q;

endmodule
`default_nettype wire

### rtl/line_sensor_position_pid.sv
// top level: sequencer, shared multiplier and pid datapath of the line sensor
//
//  channel   | dir | handshake        | payload
//  req_i     | in  | valid / ready    | func, sample_0..sample_7
//  res_o     | out | valid / ready    | position, line_output, drives, valid_mask, calibrated
//  cfg_i     | in  | valid / ready    | index, data (register write)
//
// calibrate, finish, clear and unused codes: straight from idle to done and the result register
// position only: per sensor multiply, check, divide if needed, weight multiply, add; then centroid division
// track: position plus pid steps error, p, i, d, sum, round, drive; p, i, d use the shared 17x17 multiplier
// the iterative divider (one quotient bit a cycle) takes most of the time
// reset restores gains and calibration store at once, no clearing pass
// a request is taken while the previous result still waits in res_o
`default_nettype none
module line_sensor_position_pid
  import lsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lsp_req_if.sink   req_i,
  lsp_res_if.source res_o,
  lsp_cfg_if.sink   cfg_i
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_NMUL = 16'h0002, S_NCHK = 16'h0004, S_NDIV = 16'h0008,
    S_AMUL = 16'h0010, S_AADD = 16'h0020, S_CENT = 16'h0040, S_CDIV = 16'h0080,
    S_PERR = 16'h0100, S_MP   = 16'h0200, S_MI   = 16'h0400, S_MD   = 16'h0800,
    S_SUM  = 16'h1000, S_RND  = 16'h2000, S_DRV  = 16'h4000, S_DONE = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] gain_p_q, gain_i_q, gain_d_q;
  logic [7:0]  base_q, drv_lim_q;
  logic [14:0] int_lim_q;
  logic [9:0]  min_span_q;

  // request capture
  logic [2:0]       func_q;
  sample_arr_t      raw_q, raw_in;
  logic [IDX_W-1:0] idx_q;
  logic             req_acc;

  // datapath
  logic signed [WS_W-1:0]   ws_q;
  logic [SUM_W-1:0]         s_q;
  logic [VAL_W-1:0]         val_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [POS_W-1:0]  pos_q;
  logic signed [OUT_W-1:0]  lo_q;
  logic signed [DRV_W-1:0]  left_q, right_q;

  // pid state
  logic signed [15:0]      integ_q;
  logic signed [POS_W-1:0] prev_q;
  logic signed [13:0]      e_q;
  logic signed [14:0]      d_q;

  // shared multiplier operands
  logic signed [MUL_W-1:0] mul_a, mul_b;

  // calibration store
  cal_rd_t    rd;
  logic [7:0] vmask;
  logic       calib;

  // divider
  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_num, div_den;
  logic [CNT_W-1:0] div_steps;
  logic [QUO_W-1:0] div_q;

  // result register, calibration status is frozen with the rest
  logic                    out_valid_q;
  logic signed [POS_W-1:0] r_pos_q;
  logic signed [OUT_W-1:0] r_lo_q;
  logic signed [DRV_W-1:0] r_left_q, r_right_q;
  logic [7:0]              r_mask_q;
  logic                    r_cal_q;

  // normalization helpers
  logic [SAMPLE_BITS-1:0] diff;
  logic [NUM_W-1:0]       num;
  logic                   skip_sensor, clamp_hi;
  logic [WS_W-2:0]        ws_abs;

  // pid helpers
  logic signed [13:0]  e_new;
  logic signed [14:0]  d_new;
  logic signed [17:0]  isum, ilim;
  logic signed [15:0]  integ_new;
  logic signed [ACC_W-9:0] rnd;
  logic signed [17:0]  lsum, rsum, dlim;

  assign raw_in = {req_i.sample_7, req_i.sample_6, req_i.sample_5, req_i.sample_4,
                   req_i.sample_3, req_i.sample_2, req_i.sample_1, req_i.sample_0};

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  lsp_cal u_cal (
    .clk_i, .rst_ni,
    .upd_i        (req_acc),
    .func_i       (req_i.func),
    .raw_i        (raw_in),
    .min_span_i   (min_span_q),
    .rd_idx_i     (idx_q),
    .rd_o         (rd),
    .valid_mask_o (vmask),
    .calibrated_o (calib)
  );

  // normalize: ((raw-min)*1000 + span/2) / span, quotient >= 1024 clamps early
  assign diff        = raw_q[idx_q] - rd.smin;
  assign num         = prod_q[NUM_W-1:0] + NUM_W'(rd.span >> 1);
  assign skip_sensor = !rd.valid || (rd.span == '0) || (raw_q[idx_q] <= rd.smin);
  assign clamp_hi    = num >= {rd.span, 10'b0};
  assign ws_abs      = ws_q[WS_W-1] ? (WS_W-1)'(-ws_q) : ws_q[WS_W-2:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    if (state_q == S_NCHK && !skip_sensor && !clamp_hi) begin
      div_start = 1'b1;
      div_num   = DIV_W'(num);
      div_den   = DIV_W'({rd.span, 9'b0});
      div_steps = CNT_W'(NORM_STEPS);
    end else if (state_q == S_CENT && s_q != '0) begin
      div_start = 1'b1;
      div_num   = DIV_W'(ws_abs);
      div_den   = DIV_W'({s_q, 11'b0});
      div_steps = CNT_W'(CENT_STEPS);
    end
  end

  lsp_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // one multiplier, operands picked by the sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_NMUL: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(FULL_SCALE);
      end
      S_AMUL: begin
        mul_a = MUL_W'(val_q);
        mul_b = MUL_W'(WEIGHTS[idx_q]);
      end
      S_MP: begin
        mul_a = MUL_W'(gain_p_q);
        mul_b = MUL_W'(e_q);
      end
      S_MI: begin
        mul_a = MUL_W'(gain_i_q);
        mul_b = MUL_W'(integ_q);
      end
      S_MD: begin
        mul_a = MUL_W'(gain_d_q);
        mul_b = MUL_W'(d_q);
      end
      default: ;
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // pid error terms with integral clamp
  assign e_new     = -14'(pos_q);
  assign d_new     = 15'(e_new) - 15'(prev_q);
  assign isum      = 18'(integ_q) + 18'(e_new);
  assign ilim      = 18'(int_lim_q);
  assign integ_new = (isum > ilim) ? 16'(ilim) : (isum < -ilim) ? 16'(-ilim) : 16'(isum);

  // q8 rounding is an arithmetic shift after adding one half
  assign rnd  = (ACC_W-8)'((acc_q + ACC_W'(128)) >>> 8);
  assign lsum = 18'(base_q) + 18'(lo_q);
  assign rsum = 18'(base_q) - 18'(lo_q);
  assign dlim = 18'(drv_lim_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_acc) begin
        state_d = (req_i.func == FUNC_TRACK || req_i.func == FUNC_POS) ? S_NMUL : S_DONE;
      end
      S_NMUL: state_d = S_NCHK;
      S_NCHK: state_d = div_start ? S_NDIV : S_AMUL;
      S_NDIV: if (div_done) state_d = S_AMUL;
      S_AMUL: state_d = S_AADD;
      S_AADD: state_d = (idx_q == IDX_W'(NUM_SENSORS - 1)) ? S_CENT : S_NMUL;
      S_CENT: begin
        if (div_start) state_d = S_CDIV;
        else state_d = (func_q == FUNC_TRACK) ? S_PERR : S_DONE;
      end
      S_CDIV: if (div_done) state_d = (func_q == FUNC_TRACK) ? S_PERR : S_DONE;
      S_PERR: state_d = S_MP;
      S_MP:   state_d = S_MI;
      S_MI:   state_d = S_MD;
      S_MD:   state_d = S_SUM;
      S_SUM:  state_d = S_RND;
      S_RND:  state_d = S_DRV;
      S_DRV:  state_d = S_DONE;
      S_DONE: if (!out_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      gain_p_q    <= 16'd131;
      gain_i_q    <= 16'd0;
      gain_d_q    <= 16'd287;
      base_q      <= 8'd150;
      drv_lim_q   <= 8'd255;
      int_lim_q   <= 15'd3000;
      min_span_q  <= 10'd40;
      integ_q     <= '0;
      prev_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_GAIN_P:   gain_p_q   <= cfg_i.data;
          REG_GAIN_I:   gain_i_q   <= cfg_i.data;
          REG_GAIN_D:   gain_d_q   <= cfg_i.data;
          REG_BASE:     base_q     <= cfg_i.data[7:0];
          REG_DRV_LIM:  drv_lim_q  <= cfg_i.data[7:0];
          REG_INT_LIM:  int_lim_q  <= cfg_i.data[14:0];
          REG_MIN_SPAN: min_span_q <= cfg_i.data[9:0];
          default: ;
        endcase
      end
      if (req_acc && req_i.func == FUNC_CLEAR) begin
        integ_q <= '0;
        prev_q  <= '0;
      end
      if (state_q == S_PERR) begin
        integ_q <= integ_new;
        prev_q  <= e_new[POS_W-1:0];
      end
      if (res_o.valid && res_o.ready) out_valid_q <= 1'b0;
      if (state_q == S_DONE && !out_valid_q) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (req_acc) begin
      func_q  <= req_i.func;
      raw_q   <= raw_in;
      idx_q   <= '0;
      ws_q    <= '0;
      s_q     <= '0;
      pos_q   <= '0;
      lo_q    <= '0;
      left_q  <= '0;
      right_q <= '0;
    end
    if (state_q == S_NCHK) begin
      if (skip_sensor) val_q <= '0;
      else if (clamp_hi) val_q <= VAL_W'(FULL_SCALE);
    end
    if (state_q == S_NDIV && div_done) begin
      val_q <= (div_q > QUO_W'(FULL_SCALE)) ? VAL_W'(FULL_SCALE) : div_q[VAL_W-1:0];
    end
    if (state_q == S_AADD) begin
      ws_q  <= ws_q + prod_q[WS_W-1:0];
      s_q   <= s_q + SUM_W'(val_q);
      idx_q <= idx_q + 1'b1;
    end
    if (state_q == S_CDIV && div_done) begin
      pos_q <= ws_q[WS_W-1] ? -POS_W'(div_q) : POS_W'(div_q);
    end
    if (state_q == S_PERR) begin
      e_q <= e_new;
      d_q <= d_new;
    end
    if (state_q == S_MI) acc_q <= ACC_W'(prod_q);
    if (state_q == S_MD || state_q == S_SUM) acc_q <= acc_q + ACC_W'(prod_q);
    if (state_q == S_RND) begin
      if (rnd > (ACC_W-7)'(OUT_LIMIT)) lo_q <= OUT_W'(OUT_LIMIT);
      else if (rnd < -(ACC_W-7)'(OUT_LIMIT)) lo_q <= -OUT_W'(OUT_LIMIT);
      else lo_q <= OUT_W'(rnd);
    end
    if (state_q == S_DRV) begin
      left_q  <= (lsum > dlim) ? DRV_W'(dlim) : (lsum < -dlim) ? DRV_W'(-dlim) : DRV_W'(lsum);
      right_q <= (rsum > dlim) ? DRV_W'(dlim) : (rsum < -dlim) ? DRV_W'(-dlim) : DRV_W'(rsum);
    end
    if (state_q == S_DONE && !out_valid_q) begin
      r_pos_q   <= pos_q;
      r_lo_q    <= lo_q;
      r_left_q  <= left_q;
      r_right_q <= right_q;
      r_mask_q  <= vmask;
      r_cal_q   <= calib;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.position    = r_pos_q;
  assign res_o.line_output = r_lo_q;
  assign res_o.left_drive  = r_left_q;
  assign res_o.right_drive = r_right_q;
  assign res_o.valid_mask  = r_mask_q;
  assign res_o.calibrated  = r_cal_q;

  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("result without done");
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_NDIV || state_q == S_CDIV)) else $error("divider orphaned");
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(calib)) else $error("calibrated flag dropped");

endmodule
`default_nettype wire

### tb/lsp_tb_if.sv
// testbench side helper: none needed beyond rtl interfaces; shared tb constants
package lsp_tb_pkg;
  localparam int REG_COUNT = 7;
  localparam int CYCLE_LIMIT = 2000000;
endpackage

### tb/lsp_checker.sv
// checker: predicts each result from accepted requests and register writes
module lsp_checker
  import lsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lsp_req_if.sink   req_mon,
  lsp_res_if.sink   res_mon,
  lsp_cfg_if.sink   cfg_mon,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);
  typedef struct packed {
    logic signed [12:0] position;
    logic signed [15:0] line_output;
    logic signed [8:0]  left_drive;
    logic signed [8:0]  right_drive;
    logic [7:0]         valid_mask;
    logic               calibrated;
  } steer_t;

  steer_t steer_q[$];
  longint gain_p, gain_i, gain_d, base_drive, drive_limit, integral_limit, min_span;
  longint smin[8], smax[8], sspan[8];
  logic [7:0] vbits;
  logic cal_flag;
  longint err_int, prev_err;

  function automatic longint clampv(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint line_centroid(longint raw[8]);
    longint ws, s, v;
    ws = 0; s = 0;
    for (int i = 0; i < 8; i++) begin
      if (!vbits[i] || sspan[i] == 0) continue;
      if (raw[i] <= smin[i]) v = 0;
      else begin
        v = ((raw[i] - smin[i]) * FULL_SCALE + sspan[i] / 2) / sspan[i];
        if (v > FULL_SCALE) v = FULL_SCALE;
      end
      ws += v * ((2 * i - 7) * 500);
      s += v;
    end
    if (s == 0) return 0;
    return clampv(ws / s, 4095);
  endfunction

  function automatic steer_t steer_step(logic [2:0] f, longint raw[8]);
    steer_t r;
    longint pos, lo, e, d, acc, x, sp;
    pos = 0; lo = 0;
    r = '0;
    r.left_drive = 9'sd0; r.right_drive = 9'sd0;
    case (f)
      FUNC_CAL: for (int i = 0; i < 8; i++) begin
        if (raw[i] < smin[i]) smin[i] = raw[i];
        if (raw[i] > smax[i]) smax[i] = raw[i];
      end
      FUNC_FIN: begin
        for (int i = 0; i < 8; i++) begin
          sp = (smax[i] >= smin[i]) ? smax[i] - smin[i] : 0;
          if (sp != 0 && sp >= min_span) begin
            sspan[i] = sp; vbits[i] = 1'b1;
          end else begin
            sspan[i] = 0; vbits[i] = 1'b0;
          end
        end
        cal_flag = 1'b1;
      end
      FUNC_TRACK, FUNC_POS: begin
        pos = line_centroid(raw);
        if (f == FUNC_TRACK) begin
          e = -pos;
          d = e - prev_err;
          err_int = clampv(err_int + e, integral_limit);
          acc = gain_p * e + gain_i * err_int + gain_d * d;
          prev_err = e;
          x = acc + 128;
          // floor division by 256
          lo = (x >= 0) ? x / 256 : -((-x + 255) / 256);
          lo = clampv(lo, OUT_LIMIT);
          r.left_drive = 9'(clampv(base_drive + lo, drive_limit));
          r.right_drive = 9'(clampv(base_drive - lo, drive_limit));
        end
      end
      FUNC_CLEAR: begin
        err_int = 0; prev_err = 0;
      end
      default: ;
    endcase
    r.position = 13'(pos);
    r.line_output = 16'(lo);
    r.valid_mask = vbits;
    r.calibrated = cal_flag;
    return r;
  endfunction

  assign pending_count = steer_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint raw[8];
    steer_t got, want;
    if (!rst_ni) begin
      gain_p = 131; gain_i = 0; gain_d = 287; base_drive = 150;
      drive_limit = 255; integral_limit = 3000; min_span = 40;
      for (int i = 0; i < 8; i++) begin
        smin[i] = 1023; smax[i] = 0; sspan[i] = 0;
      end
      vbits = '0; cal_flag = 1'b0; err_int = 0; prev_err = 0;
      steer_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_GAIN_P:   gain_p = cfg_mon.data;
          REG_GAIN_I:   gain_i = cfg_mon.data;
          REG_GAIN_D:   gain_d = cfg_mon.data;
          REG_BASE:     base_drive = cfg_mon.data[7:0];
          REG_DRV_LIM:  drive_limit = cfg_mon.data[7:0];
          REG_INT_LIM:  integral_limit = cfg_mon.data[14:0];
          REG_MIN_SPAN: min_span = cfg_mon.data[9:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.position, res_mon.line_output, res_mon.left_drive,
                res_mon.right_drive, res_mon.valid_mask, res_mon.calibrated};
        result_count++;
        if (steer_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = steer_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        raw = '{req_mon.sample_0, req_mon.sample_1, req_mon.sample_2, req_mon.sample_3,
                req_mon.sample_4, req_mon.sample_5, req_mon.sample_6, req_mon.sample_7};
        steer_q.push_back(steer_step(req_mon.func, raw));
      end
    end
  end
endmodule

### tb/testbench.sv
// testbench top: clock, reset, request and register stimulus, verdict
module testbench;
  import lsp_pkg::*;
  import lsp_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending_count, result_count;
  longint cycle_count = 0;
  int   burst_left = 0;
  logic hold_off = 1'b0;
  int   sent_track = 0, sent_cal = 0, sent_cfg = 0;

  lsp_req_if req_ch();
  lsp_res_if res_ch();
  lsp_cfg_if cfg_ch();

  line_sensor_position_pid u_dut (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .req_i (req_ch.sink), .res_o (res_ch.source), .cfg_i (cfg_ch.sink)
  );

  lsp_checker u_checker (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .req_mon (req_ch.sink), .res_mon (res_ch.sink), .cfg_mon (cfg_ch.sink),
    .fail_count (fail_count), .pending_count (pending_count),
    .result_count (result_count)
  );

  always #1 clk_i = ~clk_i;

  // cycle counter guards against a hung block
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** line_sensor_position_pid: FAILED **");
      $finish;
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  initial begin
    int phase_cnt;
    res_ch.ready = 1'b0;
    phase_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off) res_ch.ready <= 1'b0;
      else begin
        phase_cnt++;
        // alternate quiet stretches with ones of heavy stalling
        if ((phase_cnt / 500) % 3 == 0) res_ch.ready <= 1'b1;
        else res_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // one register write at the falling edge, wait for the handshake
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    sent_cfg++;
  endtask

  // close the current burst, wait until every predicted result has come
  task automatic drain;
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // send one request; sender idles in bursts with random gaps
  task automatic send_request(logic [2:0] f, logic [9:0] s[8]);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.sample_0 <= s[0]; req_ch.sample_1 <= s[1];
    req_ch.sample_2 <= s[2]; req_ch.sample_3 <= s[3];
    req_ch.sample_4 <= s[4]; req_ch.sample_5 <= s[5];
    req_ch.sample_6 <= s[6]; req_ch.sample_7 <= s[7];
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    // valid stays high when the next request follows at once
    if (burst_left == 0) req_ch.valid <= 1'b0;
    if (f == FUNC_TRACK) sent_track++;
    if (f == FUNC_CAL) sent_cal++;
  endtask

  task automatic send_fill(logic [2:0] f, int v);
    logic [9:0] s[8];
    foreach (s[i]) s[i] = 10'(v);
    send_request(f, s);
  endtask

  // random samples: a line bump on a random center sensor and the next, some samples pure noise
  task automatic send_random(logic [2:0] f);
    logic [9:0] s[8];
    int c;
    c = $urandom_range(0, 7);
    foreach (s[i]) begin
      if ($urandom_range(0, 4) == 0) s[i] = 10'($urandom);
      else s[i] = (i == c || i == c + 1) ? 10'($urandom_range(600, 1023))
                                         : 10'($urandom_range(0, 400));
    end
    send_request(f, s);
  endtask

  // one calibration sweep followed by finish
  task automatic calibrate_sweep(int n);
    repeat (n) send_random(FUNC_CAL);
    if ($urandom_range(0, 1)) begin
      send_fill(FUNC_CAL, 0);
      send_fill(FUNC_CAL, 1023);
    end
    send_fill(FUNC_FIN, 0);
  endtask

  task automatic random_config;
    write_reg(REG_GAIN_P, $urandom_range(0, 3) == 0 ? 16'hffff
                                                    : 16'($urandom_range(0, 1200)));
    write_reg(REG_GAIN_I, $urandom_range(0, 3) == 0 ? 16'hffff
                                                    : 16'($urandom_range(0, 200)));
    write_reg(REG_GAIN_D, 16'($urandom));
    write_reg(REG_BASE, 16'($urandom_range(0, 255)));
    write_reg(REG_DRV_LIM, 16'($urandom_range(0, 255)));
    write_reg(REG_INT_LIM, 16'($urandom_range(0, 32767)));
    write_reg(REG_MIN_SPAN, $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1023))
                                                      : 16'($urandom_range(0, 200)));
  endtask

  initial begin
    int r;
    logic [9:0] s[8];
    req_ch.valid = 1'b0; req_ch.func = FUNC_CAL;
    req_ch.sample_0 = '0; req_ch.sample_1 = '0; req_ch.sample_2 = '0;
    req_ch.sample_3 = '0; req_ch.sample_4 = '0; req_ch.sample_5 = '0;
    req_ch.sample_6 = '0; req_ch.sample_7 = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_GAIN_P; cfg_ch.data = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: uncalibrated track and position give zero, unused codes
    send_fill(FUNC_TRACK, 500);
    send_fill(FUNC_POS, 1023);
    send_fill(3'd5, 7); send_fill(3'd6, 0); send_fill(3'd7, 1023);
    // finish with no calibration: every sensor invalid
    send_fill(FUNC_FIN, 0);
    // full-range calibration, then extremes and single sensors
    send_fill(FUNC_CAL, 0); send_fill(FUNC_CAL, 1023); send_fill(FUNC_FIN, 0);
    send_fill(FUNC_TRACK, 0);
    send_fill(FUNC_TRACK, 1023);
    for (int i = 0; i < 8; i += 7) begin
      foreach (s[j]) s[j] = (j == i) ? 10'h3ff : 10'h0;
      send_request(FUNC_TRACK, s);
    end
    send_fill(FUNC_CLEAR, 0);
    // stale calibration: narrow min after finish
    foreach (s[j]) s[j] = 10'(10'h155 ^ (j * 37));
    send_request(FUNC_CAL, s);
    send_fill(FUNC_POS, 200);
    drain;
    // zero min_span, then finish again and track
    write_reg(REG_MIN_SPAN, 16'd0);
    send_fill(FUNC_FIN, 0);
    send_fill(FUNC_TRACK, 700);
    drain;
    // extreme gains and limits
    write_reg(REG_GAIN_P, 16'hffff); write_reg(REG_GAIN_I, 16'hffff);
    write_reg(REG_GAIN_D, 16'hffff); write_reg(REG_BASE, 16'd255);
    write_reg(REG_DRV_LIM, 16'd0); write_reg(REG_INT_LIM, 16'd32767);
    foreach (s[j]) s[j] = (j == 0) ? 10'h3ff : 10'h0;
    send_request(FUNC_TRACK, s);
    send_request(FUNC_TRACK, s);
    drain;

    // random phases, each after the first with its own random register setting
    for (int ph = 0; ph < 12; ph++) begin
      if (ph > 0) random_config;
      if ($urandom_range(0, 2) != 0) calibrate_sweep($urandom_range(2, 8));
      for (int k = 0; k < 100; k++) begin
        r = $urandom_range(0, 99);
        if (r < 60) send_random(FUNC_TRACK);
        else if (r < 78) send_random(FUNC_POS);
        else if (r < 84) send_fill(FUNC_CLEAR, $urandom);
        else if (r < 90) send_random(FUNC_CAL);
        else if (r < 94) send_fill(FUNC_FIN, $urandom);
        else send_random(3'($urandom_range(5, 7)));
        if (ph == 4 && k == 50) begin
          // long receiver hold-off while requests keep coming
          hold_off <= 1'b1;
          fork
            begin
              repeat (2000) @(negedge clk_i);
              hold_off <= 1'b0;
            end
          join_none
        end
      end
      if (ph == 7) drain;
      drain;
    end

    drain;
    $display("run covered %0d track requests, %0d calibrate samples, %0d register writes",
             sent_track, sent_cal, sent_cfg);
    $display("%0d results checked, %0d failures", result_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** line_sensor_position_pid: PASSED **");
    end else begin
      $display("** line_sensor_position_pid: FAILED **");
    end
    $finish;
  end
endmodule

### files.f
rtl/lsp_pkg.sv
rtl/lsp_if.sv
rtl/lsp_div.sv
rtl/lsp_cal.sv
rtl/line_sensor_position_pid.sv
tb/lsp_tb_if.sv
tb/lsp_checker.sv
tb/testbench.sv
